// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when built for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/cpra_pkg.sv -----
// Package: types, constants and codes of the contiguous page-run allocator.
`timescale 1ns / 1ps
package cpra_pkg;

   localparam int unsigned PAGE_BYTES     = 4096;
   localparam int unsigned PAGE_SHIFT     = $clog2(PAGE_BYTES);
   localparam int unsigned SLOT_COUNT_DEF = 32;
   localparam int unsigned DESC_W         = 8;

   localparam logic [DESC_W-1:0] CONT_MARK  = 8'hFF;
   localparam logic [DESC_W-1:0] DESC_FREE  = 8'h00;
   localparam logic [31:0]       BASE_RESET = 32'h003E_0000;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE         = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL   = 2'd1;
   localparam logic [1:0] ST_FREE_IGNORED = 2'd2;

   typedef struct packed {
      logic        command;
      logic [31:0] request_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [1:0]  status;
   } rsp_type;

   // write command to the descriptor store; fill=0 marks the slot free
   typedef struct packed {
      logic              en;
      logic              fill;
      logic [DESC_W-1:0] data;
   } desc_wr_type;

endpackage

// ----- sv/cpra_desc_mem.sv -----
// Descriptor store: one-port-read, one-port-write RAM with per-slot valid bits.
`timescale 1ns / 1ps
module cpra_desc_mem #(
   parameter int unsigned SLOT_COUNT = cpra_pkg::SLOT_COUNT_DEF,
   localparam int unsigned SLOT_W    = $clog2(SLOT_COUNT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [SLOT_W-1:0]               rd_addr,
   output logic [cpra_pkg::DESC_W-1:0]     rd_desc,
   input  logic [SLOT_W-1:0]               wr_addr,
   input  cpra_pkg::desc_wr_type           wr_cmd
);

   logic [cpra_pkg::DESC_W-1:0] desc_ram [SLOT_COUNT];
   logic                        valid_ff [SLOT_COUNT];
   logic [cpra_pkg::DESC_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   // data array: no reset, an entry without its valid bit reads as free
   always_ff @(posedge clock) begin
      if (wr_cmd.en && wr_cmd.fill) begin
         desc_ram[wr_addr] <= wr_cmd.data;
      end
      rd_data_ff <= desc_ram[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_cmd.en) begin
            valid_ff[wr_addr] <= wr_cmd.fill;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_desc = rd_valid_ff ? rd_data_ff : cpra_pkg::DESC_FREE;

endmodule

// ----- sv/contiguous_page_run_allocator_core.sv -----
// Top level: first-fit contiguous page-run allocator with descriptor RAM.
`timescale 1ns / 1ps
// Usage
//   req channel (valid/ready): one transfer carries a command (allocate or
//   free), a byte count for allocate and an address for free.
//   rsp channel (valid/ready): exactly one transfer per request, with the
//   granted address (0 unless an allocation succeeds) and a status code.
//   csr port: csr_wr_en writes region_base from csr_wr_data at once; write it
//   only while no request is in flight.
// Sequence (accepting edge to the edge that raises rsp_valid)
//   Allocate: the scan reads one slot a cycle up to the slot that completes
//   the run, then writes the run's descriptors and loads the result; if no
//   run fits, it stops at the last slot. Free: the head descriptor is read
//   and checked, then, if it heads a run, its pages are cleared. A rejected
//   request goes straight to the result; req_ready rises as it loads.
// Reset
//   Synchronous, active high: every slot becomes free (its valid bit is
//   cleared), region_base returns to its reset value, both channels idle.
// Back-pressure
//   The result sits in an output register; a new request is taken while it
//   waits, and the next result holds in the sequencer until rsp_ready.
module contiguous_page_run_allocator_core #(
   parameter int unsigned SLOT_COUNT = cpra_pkg::SLOT_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpra_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

`include "assert_macros.svh"

   localparam int unsigned SLOT_W       = $clog2(SLOT_COUNT);
   localparam int unsigned CNT_W        = $clog2(SLOT_COUNT + 1);
   localparam int unsigned PG_W         = 33 - cpra_pkg::PAGE_SHIFT;
   localparam logic [31:0] REGION_BYTES = 32'(SLOT_COUNT * cpra_pkg::PAGE_BYTES);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_FREAD = 3'd3;
   localparam logic [2:0] S_FCHK  = 3'd4;
   localparam logic [2:0] S_FCLR  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [31:0]       region_base_ff;
   logic [CNT_W-1:0]  pages_ff, pages_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]  run_len_ff, run_len_in;
   logic [SLOT_W-1:0] start_ff, start_in;
   logic [SLOT_W-1:0] end_ff, end_in;
   logic [SLOT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [cpra_pkg::DESC_W-1:0] left_ff, left_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cpra_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [SLOT_W-1:0]           mem_raddr;
   logic [cpra_pkg::DESC_W-1:0] rd_desc;
   cpra_pkg::desc_wr_type       wr_cmd;

   logic              req_fire;
   logic [PG_W-1:0]   req_pages;
   logic              alloc_bad;
   logic [31:0]       free_offset;
   logic              free_in_region;
   logic [CNT_W-1:0]  run_next;
   logic [SLOT_W-1:0] run_head;
   logic              rsp_free;

   cpra_desc_mem #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_desc_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_raddr),
      .rd_desc (rd_desc),
      .wr_addr (wr_idx_ff),
      .wr_cmd  (wr_cmd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // page count without wrap: whole pages plus one for a partial page
   assign req_pages = PG_W'(req_data.request_bytes[31:cpra_pkg::PAGE_SHIFT])
                    + PG_W'(|req_data.request_bytes[cpra_pkg::PAGE_SHIFT-1:0]);
   assign alloc_bad = (req_data.request_bytes == 32'd0) ||
                      (req_pages > PG_W'(SLOT_COUNT));

   // region check; offset is only meaningful when address >= base
   assign free_offset    = req_data.free_address - region_base_ff;
   assign free_in_region = (req_data.free_address >= region_base_ff) &&
                           (free_offset < REGION_BYTES);

   // free-run tracking for the slot whose descriptor arrives this cycle
   assign run_next = run_len_ff + CNT_W'(1);
   assign run_head = (run_len_ff == '0) ? chk_idx_ff : start_ff;

   always_comb begin
      if (state_ff == S_SCAN && scan_ff < CNT_W'(SLOT_COUNT)) begin
         mem_raddr = scan_ff[SLOT_W-1:0];
      end else if (state_ff == S_SCAN) begin
         mem_raddr = '0;
      end else begin
         mem_raddr = wr_idx_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pages_in      = pages_ff;
      scan_in       = scan_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      run_len_in    = run_len_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      wr_idx_in     = wr_idx_ff;
      left_in       = left_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      wr_cmd        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_addr_in = 32'd0;
               if (req_data.command == cpra_pkg::CMD_ALLOC) begin
                  pages_in   = CNT_W'(req_pages);
                  scan_in    = '0;
                  chk_vld_in = 1'b0;
                  run_len_in = '0;
                  if (alloc_bad) begin
                     res_status_in = cpra_pkg::ST_ALLOC_FAIL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  wr_idx_in = SLOT_W'(free_offset >> cpra_pkg::PAGE_SHIFT);
                  if (free_in_region) begin
                     state_in = S_FREAD;
                  end else begin
                     res_status_in = cpra_pkg::ST_FREE_IGNORED;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_SCAN: begin
            // issue side: one read per cycle, slot index follows the data
            if (scan_ff < CNT_W'(SLOT_COUNT)) begin
               scan_in    = scan_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[SLOT_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            // check side
            if (chk_vld_ff) begin
               if (rd_desc != cpra_pkg::DESC_FREE) begin
                  run_len_in = '0;
                  if (chk_idx_ff == LAST_SLOT) begin
                     res_status_in = cpra_pkg::ST_ALLOC_FAIL;
                     state_in      = S_DONE;
                  end
               end else begin
                  run_len_in = run_next;
                  start_in   = run_head;
                  if (run_next == pages_ff) begin
                     wr_idx_in = run_head;
                     end_in    = chk_idx_ff;
                     state_in  = S_FILL;
                  end else if (chk_idx_ff == LAST_SLOT) begin
                     res_status_in = cpra_pkg::ST_ALLOC_FAIL;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_FILL: begin
            wr_cmd.en   = 1'b1;
            wr_cmd.fill = 1'b1;
            wr_cmd.data = (wr_idx_ff == start_ff) ?
                          cpra_pkg::DESC_W'(pages_ff) : cpra_pkg::CONT_MARK;
            if (wr_idx_ff == end_ff) begin
               res_addr_in   = region_base_ff +
                               (32'(start_ff) << cpra_pkg::PAGE_SHIFT);
               res_status_in = cpra_pkg::ST_DONE;
               state_in      = S_DONE;
            end else begin
               wr_idx_in = wr_idx_ff + SLOT_W'(1);
            end
         end
         S_FREAD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (rd_desc == cpra_pkg::DESC_FREE || rd_desc == cpra_pkg::CONT_MARK) begin
               res_status_in = cpra_pkg::ST_FREE_IGNORED;
               state_in      = S_DONE;
            end else begin
               left_in  = rd_desc;
               state_in = S_FCLR;
            end
         end
         S_FCLR: begin
            wr_cmd.en = 1'b1;
            // clearing stops at the recorded count or at the last slot
            if (left_ff == cpra_pkg::DESC_W'(1) || wr_idx_ff == LAST_SLOT) begin
               res_status_in = cpra_pkg::ST_DONE;
               state_in      = S_DONE;
            end else begin
               left_in   = left_ff - cpra_pkg::DESC_W'(1);
               wr_idx_in = wr_idx_ff + SLOT_W'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.granted_address = res_addr_ff;
         rsp_data_in.status          = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         chk_vld_ff     <= 1'b0;
         region_base_ff <= cpra_pkg::BASE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         if (csr_wr_en) begin
            region_base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pages_ff      <= pages_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      run_len_ff    <= run_len_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      wr_idx_ff     <= wr_idx_in;
      left_ff       <= left_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a request always leaves idle
   `ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   // the run being filled is exactly the requested length
   `ASSERT_IMPLY(a_fill_len, clock, reset, state_ff == S_FILL,
                 CNT_W'(end_ff - start_ff) + CNT_W'(1) == pages_ff)
   // only a successful allocation carries an address
   `ASSERT_IMPLY(a_fail_no_addr, clock, reset,
                 rsp_valid && rsp_data.status != cpra_pkg::ST_DONE,
                 rsp_data.granted_address == 32'd0)

endmodule

// ----- dv/tb_contiguous_page_run_allocator_core.sv -----
// Testbench: first-fit page-run allocator core checked against a slot-map predictor.
`timescale 1ns / 1ps
module tb_contiguous_page_run_allocator_core;
   import cpra_pkg::*;

   localparam int unsigned SLOTS        = SLOT_COUNT_DEF;
   localparam int unsigned REGION_BYTES = SLOTS * PAGE_BYTES;
   // drain time after the owed results, longer than the slowest single request
   localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 8;
   localparam logic [31:0] BASE_TOP      = 32'hFFFE_0000;   // highest legal region_base

   typedef enum {SLOT_FREE, SLOT_HEAD, SLOT_CONT} slot_kind_e;

   // Slot-map model of the allocator plus the queue of results still owed by the core.
   class page_run_scoreboard;
      logic [DESC_W-1:0] slot_desc [SLOTS];
      logic [31:0]       base;
      rsp_type           owed_q[$];
      int unsigned       mismatches;
      int unsigned       requests;
      int unsigned       grants;
      int unsigned       alloc_fails;
      int unsigned       frees_done;
      int unsigned       frees_ignored;

      function new();
         mismatches = 0;
         requests   = 0;
         grants     = 0;
         alloc_fails   = 0;
         frees_done    = 0;
         frees_ignored = 0;
         clear();
      endfunction

      function void clear();
         foreach (slot_desc[i]) slot_desc[i] = DESC_FREE;
         base = BASE_RESET;
         owed_q.delete();
      endfunction

      function void set_base(logic [31:0] value);
         base = value;
      endfunction

      function logic [31:0] slot_address(int slot);
         return base + 32'(slot) * PAGE_BYTES;
      endfunction

      // first fit over the slot map; page count kept wide so huge sizes cannot wrap
      function rsp_type grant_pages(logic [31:0] bytes);
         rsp_type     r;
         logic [32:0] pages;
         int unsigned run_len;
         int unsigned head_slot;
         r.granted_address = '0;
         r.status          = ST_ALLOC_FAIL;
         pages = ({1'b0, bytes} + 33'(PAGE_BYTES - 1)) / 33'(PAGE_BYTES);
         if (bytes == 0 || pages > 33'(SLOTS)) return r;
         run_len   = 0;
         head_slot = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_desc[i] != DESC_FREE) begin
               run_len = 0;
            end else begin
               if (run_len == 0) head_slot = i;
               run_len++;
               if (run_len == pages) begin
                  slot_desc[head_slot] = DESC_W'(pages);
                  for (int j = head_slot + 1; j <= i; j++) slot_desc[j] = CONT_MARK;
                  r.granted_address = base + 32'(head_slot) * PAGE_BYTES;
                  r.status          = ST_DONE;
                  return r;
               end
            end
         end
         return r;
      endfunction

      // region bound taken in 33 bits, so a region ending at 2^32 does not wrap
      function rsp_type release_run(logic [31:0] addr);
         rsp_type           r;
         logic [32:0]       region_end;
         int unsigned       slot;
         logic [DESC_W-1:0] count;
         r.granted_address = '0;
         r.status          = ST_FREE_IGNORED;
         region_end = {1'b0, base} + 33'(REGION_BYTES);
         if (addr < base || {1'b0, addr} >= region_end) return r;
         slot = (addr - base) / PAGE_BYTES;
         if (slot >= SLOTS) return r;
         count = slot_desc[slot];
         if (count == DESC_FREE || count == CONT_MARK) return r;
         for (int k = 0; k < count && slot + k < SLOTS; k++) slot_desc[slot + k] = DESC_FREE;
         r.status = ST_DONE;
         return r;
      endfunction

      function void note_request(req_type item);
         rsp_type r;
         if (item.command == CMD_ALLOC) begin
            r = grant_pages(item.request_bytes);
            if (r.status == ST_DONE) grants++;
            else alloc_fails++;
         end else begin
            r = release_run(item.free_address);
            if (r.status == ST_DONE) frees_done++;
            else frees_ignored++;
         end
         requests++;
         owed_q.push_back(r);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            report($sformatf("result addr=%h status=%0d with no request outstanding",
                             got.granted_address, got.status));
         end else begin
            want = owed_q.pop_front();
            if (got.granted_address !== want.granted_address)
               report($sformatf("granted_address %h, expected %h",
                                got.granted_address, want.granted_address));
            if (got.status !== want.status)
               report($sformatf("status %0d, expected %0d", got.status, want.status));
         end
      endtask

      function int pick_slot(slot_kind_e kind);
         int hits[$];
         bit hit;
         foreach (slot_desc[i]) begin
            case (kind)
               SLOT_FREE: hit = (slot_desc[i] == DESC_FREE);
               SLOT_CONT: hit = (slot_desc[i] == CONT_MARK);
               default:   hit = (slot_desc[i] != DESC_FREE && slot_desc[i] != CONT_MARK);
            endcase
            if (hit) hits.push_back(i);
         end
         if (hits.size() == 0) return -1;
         return hits[$urandom_range(0, hits.size() - 1)];
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   page_run_scoreboard sb;
   bit                 no_idle;        // both sides run back to back while set
   int unsigned        base_settings;

   contiguous_page_run_allocator_core #(
      .SLOT_COUNT (SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timeout: results still outstanding or core stuck");
      $display("CHECKS FAILED");
      $finish;
   end

   // Every completed result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // Result side: random stall before each transfer. Ready is only lowered when a
   // stall is drawn, so a zero stall keeps it high across back-to-back transfers.
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type alloc_req(logic [31:0] bytes);
      req_type item;
      item.command       = CMD_ALLOC;
      item.request_bytes = bytes;
      item.free_address  = $urandom();      // unused by allocate, still toggled
      return item;
   endfunction

   function automatic req_type free_req(logic [31:0] addr);
      req_type item;
      item.command       = CMD_FREE;
      item.request_bytes = $urandom();      // unused by free, still toggled
      item.free_address  = addr;
      return item;
   endfunction

   // Mostly small allocations and frees of live runs; the rest hits the odd cases:
   // huge and zero sizes, frees of continuation/free slots and out-of-region addresses.
   function automatic req_type random_request();
      int unsigned pick;
      int          slot;
      logic [31:0] bytes;
      logic [31:0] addr;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
         if (pick < 60)      bytes = $urandom_range(1, 4 * PAGE_BYTES);
         else if (pick < 80) bytes = $urandom_range(1, REGION_BYTES);
         else if (pick < 88) bytes = $urandom_range(1, SLOTS) * PAGE_BYTES;
         else if (pick < 94) bytes = $urandom();
         else if (pick < 97) bytes = '0;
         else                bytes = REGION_BYTES + $urandom_range(1, PAGE_BYTES);
         return alloc_req(bytes);
      end
      if (pick < 70)      slot = sb.pick_slot(SLOT_HEAD);
      else if (pick < 80) slot = sb.pick_slot(SLOT_CONT);
      else if (pick < 88) slot = sb.pick_slot(SLOT_FREE);
      else                slot = -1;
      if (slot >= 0)
         addr = sb.slot_address(slot) + $urandom_range(0, PAGE_BYTES - 1);
      else if (pick < 94)
         addr = ($urandom_range(0, 1) == 0) ? sb.base - $urandom_range(1, PAGE_BYTES)
                                            : sb.base + REGION_BYTES
                                              + $urandom_range(0, PAGE_BYTES);
      else
         addr = $urandom();
      return free_req(addr);
   endfunction

   // One request transfer. Valid drops only when a gap is drawn, so a zero gap
   // presents the next payload in the same step as the previous acceptance.
   task automatic send_request(req_type item);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   // Hold off the request side until every owed result has come back, then let
   // the core settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the core idle (after a drain).
   task automatic write_base(logic [31:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_base(value);
      base_settings++;
   endtask

   task automatic run_random_phase(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         no_idle = ((i / 40) % 4 == 3);
         if (i == count / 2) drain_results();   // mid-phase quiet point
         send_request(random_request());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      logic [31:0] b;
      sb            = new();
      no_idle       = 1'b0;
      base_settings = 1;           // the reset value counts as the first setting
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sb.clear();

      // Directed part at the reset base.
      b = BASE_RESET;
      send_request(alloc_req(32'd0));                    // zero size
      send_request(alloc_req(32'd1));                    // slot 0
      send_request(alloc_req(PAGE_BYTES));               // slot 1
      send_request(alloc_req(PAGE_BYTES + 1));           // slots 2..3
      send_request(alloc_req(32'hFFFF_FFFF));            // page count must not wrap
      send_request(alloc_req(REGION_BYTES + 1));         // one page too many
      send_request(alloc_req(32'hFFFF_F001));
      send_request(free_req(b + 3 * PAGE_BYTES));        // continuation slot
      send_request(free_req(b + 2 * PAGE_BYTES + 12'h123));   // unaligned head
      send_request(free_req(b + 2 * PAGE_BYTES));        // already free
      send_request(free_req(b - 1));                     // just below region
      send_request(free_req(b + REGION_BYTES));          // just past region
      send_request(free_req(b + REGION_BYTES - 1));      // last slot, free
      send_request(free_req(32'd0));
      send_request(free_req(32'hFFFF_FFFF));
      send_request(alloc_req((SLOTS - 3) * PAGE_BYTES)); // fills 2..30
      send_request(alloc_req(2 * PAGE_BYTES));           // no run long enough
      send_request(alloc_req(32'd1));                    // last slot
      send_request(free_req(b));
      send_request(free_req(b + (SLOTS - 1) * PAGE_BYTES + 12'hFFF));
      send_request(free_req(b + 2 * PAGE_BYTES));
      send_request(free_req(b + PAGE_BYTES));
      send_request(alloc_req(REGION_BYTES));             // whole region
      send_request(free_req(b));
      drain_results();

      // Base 0: slot 0 yields a granted address of 0 with status done.
      write_base(32'd0);
      send_request(alloc_req(32'd1));
      send_request(free_req(32'd0));
      run_random_phase(205);
      drain_results();

      // Region ends exactly at 2^32.
      write_base(BASE_TOP);
      run_random_phase(205);
      drain_results();

      write_base(32'($urandom_range(0, BASE_TOP >> PAGE_SHIFT)) << PAGE_SHIFT);
      run_random_phase(205);
      drain_results();

      write_base(32'($urandom_range(0, BASE_TOP >> PAGE_SHIFT)) << PAGE_SHIFT);
      run_random_phase(205);
      drain_results();

      write_base(BASE_RESET);
      run_random_phase(205);
      drain_results();

      $display("Covered %0d requests over %0d region bases: %0d grants, %0d failed allocations,",
               sb.requests, base_settings, sb.grants, sb.alloc_fails);
      $display("%0d frees and %0d ignored frees; %0d mismatches.",
               sb.frees_done, sb.frees_ignored, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- contiguous_page_run_allocator_core.f -----
+incdir+sv
sv/cpra_pkg.sv
sv/cpra_desc_mem.sv
sv/contiguous_page_run_allocator_core.sv
dv/tb_contiguous_page_run_allocator_core.sv
